[hdl/tga_rle_span_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the run-length span decoder
// Shared property templates used by the checker that binds to the top level.
// ----------------------------------------------------------------------------
`ifndef TGA_RLE_SPAN_DECODER_DEFINES_SVH
`define TGA_RLE_SPAN_DECODER_DEFINES_SVH

// The expression must hold at every clock edge outside reset.
`define TGA_ASSERT_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("span decoder check failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define TGA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("span decoder check failed");

`endif

[hdl/tga_rle_pkg.sv]
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Types, widths and register codes shared by the span decoder files.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  localparam int DEF_MAX_PIXEL_BYTES = 4;
  localparam int DEF_DIM_BITS        = 16;

  localparam int BYTE_W      = 8;
  localparam int PIXEL_W     = 32;
  localparam int DIM_FIELD_W = 16;
  localparam int LEN_W       = 8;
  localparam int BPP_W       = 3;
  localparam int DATA_W      = 32;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = REG_IDX_W + 2;

  // Header byte layout.
  localparam int                  REPEAT_BIT = 7;
  localparam logic [BYTE_W-2:0]   COUNT_MASK = 7'h7F;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_BPP    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RTL    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TTB    = 3'd4;

  localparam logic [BPP_W-1:0]       RST_BPP    = 3'd3;
  localparam logic [DIM_FIELD_W-1:0] RST_WIDTH  = 16'd1;
  localparam logic [DIM_FIELD_W-1:0] RST_HEIGHT = 16'd1;

  typedef struct packed {
    logic [BPP_W-1:0]       bytes_per_pixel;
    logic [DIM_FIELD_W-1:0] image_width;
    logic [DIM_FIELD_W-1:0] image_height;
    logic                   right_to_left;
    logic                   top_to_bottom;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]     pixel_value;
    logic [DIM_FIELD_W-1:0] start_column;
    logic [DIM_FIELD_W-1:0] row;
    logic [LEN_W-1:0]       span_length;
    logic                   image_done;
  } span_t;

endpackage

[hdl/tga_rle_ifs.sv]
// ----------------------------------------------------------------------------
// Stream interfaces
// Byte input channel and span result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tga_rle_byte_if;
  import tga_rle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface tga_rle_span_if;
  import tga_rle_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PIXEL_W-1:0]     pixel_value;
  logic [DIM_FIELD_W-1:0] start_column;
  logic [DIM_FIELD_W-1:0] row;
  logic [LEN_W-1:0]       span_length;
  logic                   image_done;

  modport source (output valid, output pixel_value, output start_column, output row,
                  output span_length, output image_done, input ready);
  modport sink   (input valid, input pixel_value, input start_column, input row,
                  input span_length, input image_done, output ready);
endinterface

[hdl/tga_rle_cfg.sv]
// ----------------------------------------------------------------------------
// tga_rle_cfg
// APB register block holding pixel size, image size and orientation flags.
// ----------------------------------------------------------------------------
module tga_rle_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tga_rle_pkg::ADDR_W-1:0] paddr,
  input  logic [tga_rle_pkg::DATA_W-1:0] pwdata,
  output logic [tga_rle_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output tga_rle_pkg::cfg_t              cfg
);
  import tga_rle_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_pixel <= RST_BPP;
      cfg.image_width     <= RST_WIDTH;
      cfg.image_height    <= RST_HEIGHT;
      cfg.right_to_left   <= 1'b0;
      cfg.top_to_bottom   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BPP:    cfg.bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_WIDTH:  cfg.image_width     <= pwdata[DIM_FIELD_W-1:0];
        REG_HEIGHT: cfg.image_height    <= pwdata[DIM_FIELD_W-1:0];
        REG_RTL:    cfg.right_to_left   <= pwdata[0];
        REG_TTB:    cfg.top_to_bottom   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BPP:    prdata = DATA_W'(cfg.bytes_per_pixel);
      REG_WIDTH:  prdata = DATA_W'(cfg.image_width);
      REG_HEIGHT: prdata = DATA_W'(cfg.image_height);
      REG_RTL:    prdata = DATA_W'(cfg.right_to_left);
      REG_TTB:    prdata = DATA_W'(cfg.top_to_bottom);
      default:    prdata = '0;
    endcase
  end

endmodule

[hdl/tga_rle_core.sv]
// ----------------------------------------------------------------------------
// tga_rle_core
// Input byte register, packet and line state, and the span computation.
// ----------------------------------------------------------------------------
module tga_rle_core #(
  parameter int MAX_PIXEL_BYTES = tga_rle_pkg::DEF_MAX_PIXEL_BYTES,
  parameter int DIM_BITS        = tga_rle_pkg::DEF_DIM_BITS
) (
  input  logic               clk,
  input  logic               rst,
  tga_rle_byte_if.sink       stream,
  input  tga_rle_pkg::cfg_t  cfg,
  input  logic               slot_free,
  output logic               load,
  output tga_rle_pkg::span_t span
);
  import tga_rle_pkg::*;

  localparam int ACC_W = BYTE_W * MAX_PIXEL_BYTES;
  localparam int BC_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(MAX_PIXEL_BYTES);

  // Input stage.
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // Decoder state.
  logic                expect_header;
  logic                repeat_packet;
  logic [LEN_W-1:0]    run_left;
  logic [BC_W-1:0]     byte_count;
  logic [ACC_W-1:0]    pixel_acc;
  logic [DIM_BITS-1:0] line_pos;
  logic [DIM_BITS-1:0] line_num;
  logic                frame_finished;

  logic [BPP_W-1:0]    bpp_eff;
  logic [DIM_BITS-1:0] width_eff;
  logic [DIM_BITS-1:0] height_eff;
  logic [ACC_W-1:0]    acc_merged;
  logic                last_byte;
  logic                produce;
  logic                fire;
  logic [DIM_BITS-1:0] remaining;
  logic [LEN_W-1:0]    run_len;
  logic [DIM_BITS-1:0] len_dim;
  logic [DIM_BITS-1:0] col;
  logic [DIM_BITS-1:0] row_mem;
  logic [DIM_BITS:0]   pos_sum;
  logic [DIM_BITS:0]   line_inc;
  logic                line_end;
  logic                frame_end;
  logic [LEN_W-1:0]    run_dec;

  always_comb begin
    priority if (cfg.bytes_per_pixel == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (cfg.bytes_per_pixel > MAX_BPP) begin
      bpp_eff = MAX_BPP;
    end else begin
      bpp_eff = cfg.bytes_per_pixel;
    end
  end

  assign width_eff  = (cfg.image_width[DIM_BITS-1:0] == '0) ?
                      DIM_BITS'(1) : cfg.image_width[DIM_BITS-1:0];
  assign height_eff = (cfg.image_height[DIM_BITS-1:0] == '0) ?
                      DIM_BITS'(1) : cfg.image_height[DIM_BITS-1:0];

  // Stream bytes land little-endian in the accumulator.
  assign acc_merged = pixel_acc | (ACC_W'(in_byte) << {byte_count, 3'b000});
  assign last_byte  = (BPP_W'(byte_count) + BPP_W'(1)) >= bpp_eff;

  assign produce = in_valid && !frame_finished && !expect_header && last_byte;
  assign fire    = in_valid && (!produce || slot_free);
  assign load    = fire && produce;

  assign stream.ready = !in_valid || fire;

  // A line position already past the width (width lowered mid-image) gets one pixel.
  assign remaining = (line_pos < width_eff) ? (width_eff - line_pos) : DIM_BITS'(1);
  assign run_len   = (repeat_packet && run_left != '0) ? run_left : LEN_W'(1);
  assign len_dim   = (DIM_BITS'(run_len) > remaining) ? remaining : DIM_BITS'(run_len);

  assign col     = cfg.right_to_left ? (width_eff - DIM_BITS'(1) - line_pos) : line_pos;
  assign row_mem = cfg.top_to_bottom ? line_num : (height_eff - DIM_BITS'(1) - line_num);

  assign pos_sum   = {1'b0, line_pos} + {1'b0, len_dim};
  assign line_end  = pos_sum >= {1'b0, width_eff};
  assign line_inc  = {1'b0, line_num} + (DIM_BITS + 1)'(1);
  assign frame_end = line_end && (line_inc >= {1'b0, height_eff});
  assign run_dec   = run_left - LEN_W'(1);

  assign span.pixel_value  = PIXEL_W'(acc_merged);
  assign span.start_column = DIM_FIELD_W'(col);
  assign span.row          = DIM_FIELD_W'(row_mem);
  assign span.span_length  = LEN_W'(len_dim);
  assign span.image_done   = frame_end;

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      expect_header  <= 1'b1;
      repeat_packet  <= 1'b0;
      run_left       <= '0;
      byte_count     <= '0;
      pixel_acc      <= '0;
      line_pos       <= '0;
      line_num       <= '0;
      frame_finished <= 1'b0;
    end else begin
      if (stream.ready) begin
        in_valid <= stream.valid;
      end
      if (fire && !frame_finished) begin
        if (expect_header) begin
          repeat_packet <= in_byte[REPEAT_BIT];
          run_left      <= {1'b0, in_byte[BYTE_W-2:0] & COUNT_MASK} + LEN_W'(1);
          byte_count    <= '0;
          pixel_acc     <= '0;
          expect_header <= 1'b0;
        end else if (!last_byte) begin
          byte_count <= byte_count + BC_W'(1);
          pixel_acc  <= acc_merged;
        end else begin
          byte_count <= '0;
          pixel_acc  <= '0;
          if (!repeat_packet) begin
            run_left <= run_dec;
          end
          if (line_end) begin
            line_pos      <= '0;
            expect_header <= 1'b1;
            line_num      <= line_inc[DIM_BITS-1:0];
            if (frame_end) begin
              frame_finished <= 1'b1;
            end
          end else begin
            line_pos      <= pos_sum[DIM_BITS-1:0];
            expect_header <= repeat_packet || (run_dec == '0);
          end
        end
      end
    end
  end

endmodule

[hdl/tga_rle_out_reg.sv]
// ----------------------------------------------------------------------------
// tga_rle_out_reg
// Result register that holds one span until the consumer takes it.
// ----------------------------------------------------------------------------
module tga_rle_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tga_rle_pkg::span_t span,
  output logic               slot_free,
  tga_rle_span_if.source     spans
);
  import tga_rle_pkg::*;

  logic  valid;
  span_t held;

  assign slot_free = !valid || spans.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (spans.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= span;
    end
  end

  assign spans.valid        = valid;
  assign spans.pixel_value  = held.pixel_value;
  assign spans.start_column = held.start_column;
  assign spans.row          = held.row;
  assign spans.span_length  = held.span_length;
  assign spans.image_done   = held.image_done;

endmodule

[hdl/tga_rle_span_decoder.sv]
// ----------------------------------------------------------------------------
// tga_rle_span_decoder
// Run-length Targa pixel stream decoder producing positioned pixel spans.
// ----------------------------------------------------------------------------
// The decoder takes one compressed byte per clock cycle, sustained, as long as the
// span output is drained: each byte needs only one update of the packet and line
// counters between the input byte register and the span result register. A span is
// valid on the output once its last pixel byte has passed the input byte register
// and the span is loaded into the result register. Header bytes and partial pixel
// bytes give no span. After the span that completes the last line, further bytes
// are consumed and dropped until reset. There is no clearing pass after reset. The
// user must write registers over APB only while the decoder is idle (not enforced).
module tga_rle_span_decoder #(
  parameter int MAX_PIXEL_BYTES = tga_rle_pkg::DEF_MAX_PIXEL_BYTES,
  parameter int DIM_BITS        = tga_rle_pkg::DEF_DIM_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tga_rle_pkg::ADDR_W-1:0] paddr,
  input  logic [tga_rle_pkg::DATA_W-1:0] pwdata,
  output logic [tga_rle_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  tga_rle_byte_if.sink                   stream,
  tga_rle_span_if.source                 spans
);
  import tga_rle_pkg::*;

  cfg_t  cfg;
  span_t span;
  logic  load;
  logic  slot_free;

  tga_rle_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tga_rle_core #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .DIM_BITS        (DIM_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .cfg       (cfg),
    .slot_free (slot_free),
    .load      (load),
    .span      (span)
  );

  tga_rle_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .span      (span),
    .slot_free (slot_free),
    .spans     (spans)
  );

endmodule

[hdl/tga_rle_chk.sv]
// ----------------------------------------------------------------------------
// tga_rle_chk
// Port-level checks on the span output of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "tga_rle_span_decoder_defines.svh"

module tga_rle_chk (
  input logic        clk,
  input logic        rst,
  input logic        spans_valid,
  input logic        spans_ready,
  input logic [31:0] pixel_value,
  input logic [15:0] start_column,
  input logic [15:0] row,
  input logic [7:0]  span_length,
  input logic        image_done
);

  logic done_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      done_seen <= 1'b0;
    end else if (spans_valid && spans_ready && image_done) begin
      done_seen <= 1'b1;
    end
  end

  `TGA_ASSERT_ALWAYS(a_len_range, clk, rst,
    !spans_valid || (span_length != 8'd0 && span_length <= 8'd128))

  // Once the finishing span is taken, the decoder stays silent until reset.
  `TGA_ASSERT_ALWAYS(a_quiet_after_done, clk, rst, !(done_seen && spans_valid))

  `TGA_ASSERT_NEXT(a_valid_holds, clk, rst, spans_valid && !spans_ready, spans_valid)

  `TGA_ASSERT_NEXT(a_payload_holds, clk, rst, spans_valid && !spans_ready,
    $stable(pixel_value) && $stable(start_column) && $stable(row) &&
    $stable(span_length) && $stable(image_done))

endmodule

bind tga_rle_span_decoder tga_rle_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .spans_valid  (spans.valid),
  .spans_ready  (spans.ready),
  .pixel_value  (spans.pixel_value),
  .start_column (spans.start_column),
  .row          (spans.row),
  .span_length  (spans.span_length),
  .image_done   (spans.image_done)
);

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Testbench for tga_rle_span_decoder
// Feeds run-length coded pixel streams through the byte channel under several
// image geometries, pixel sizes and orientations, predicts every span, and
// checks each span field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tga_rle_pkg::*;

  localparam int TARGET_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;

  typedef struct {
    bit               expect_header;
    bit               repeat_packet;
    logic [7:0]       run_left;
    logic [1:0]       byte_count;
    logic [PIXEL_W-1:0] accum;
    logic [15:0]      line_pos;
    logic [15:0]      line_num;
    bit               finished;
  } decode_state_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  tga_rle_byte_if bytes_in ();
  tga_rle_span_if spans_out ();

  tga_rle_span_decoder uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stream  (bytes_in),
    .spans   (spans_out)
  );

  cfg_t          cfg;
  decode_state_t gen_state;
  decode_state_t chk_state;
  logic [7:0]    byte_q[$];
  span_t         span_q[$];
  int            item_count;
  bit            failed;
  bit            gaps_on;
  bit            byte_taken;
  int            hold_reqs;
  int            holds_served;
  int            hold_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pixel_bytes(input cfg_t c);
    if (c.bytes_per_pixel == '0) return 1;
    if (c.bytes_per_pixel > 3'd4) return 4;
    return int'(c.bytes_per_pixel);
  endfunction

  function automatic int eff_dim(input logic [15:0] v);
    return (v == 16'd0) ? 1 : int'(v);
  endfunction

  // Advances the decoder state by one stream byte; returns 1 when a span results.
  function automatic bit decode_byte(inout decode_state_t st, input cfg_t c,
                                     input logic [7:0] b, output span_t sp);
    int w;
    int h;
    int rem;
    int len;
    int pos_next;
    int line_next;
    int col;
    int row_v;
    sp = '0;
    if (st.finished) return 1'b0;
    if (st.expect_header) begin
      st.repeat_packet = b[REPEAT_BIT];
      st.run_left      = {1'b0, b[6:0]} + 8'd1;
      st.byte_count    = '0;
      st.accum         = '0;
      st.expect_header = 1'b0;
      return 1'b0;
    end
    st.accum = st.accum | ({24'd0, b} << (8 * st.byte_count));
    if (int'(st.byte_count) + 1 < pixel_bytes(c)) begin
      st.byte_count = st.byte_count + 2'd1;
      return 1'b0;
    end
    st.byte_count = '0;
    sp.pixel_value = st.accum;
    st.accum = '0;

    w   = eff_dim(c.image_width);
    h   = eff_dim(c.image_height);
    rem = (int'(st.line_pos) < w) ? (w - int'(st.line_pos)) : 1;
    len = st.repeat_packet ? int'(st.run_left) : 1;
    if (len == 0) len = 1;
    if (len > rem) len = rem;

    col   = c.right_to_left ? ((w - 1 - int'(st.line_pos)) & 'hFFFF) : int'(st.line_pos);
    row_v = c.top_to_bottom ? int'(st.line_num) : ((h - 1 - int'(st.line_num)) & 'hFFFF);

    pos_next = int'(st.line_pos) + len;
    if (st.repeat_packet) begin
      st.expect_header = 1'b1;
    end else begin
      st.run_left = st.run_left - 8'd1;
      if (st.run_left == 8'd0) st.expect_header = 1'b1;
    end

    if (pos_next >= w) begin
      pos_next = 0;
      st.expect_header = 1'b1;
      line_next = int'(st.line_num) + 1;
      if (line_next >= h) begin
        st.finished = 1'b1;
        sp.image_done = 1'b1;
      end
      st.line_num = line_next[15:0];
    end
    st.line_pos = pos_next[15:0];

    sp.start_column = col[15:0];
    sp.row          = row_v[15:0];
    sp.span_length  = len[7:0];
    return 1'b1;
  endfunction

  // The generator runs its own copy of the decoder so that packets line up.
  task automatic push_byte(input logic [7:0] b);
    span_t unused;
    void'(decode_byte(gen_state, cfg, b, unused));
    byte_q.push_back(b);
    item_count++;
  endtask

  task automatic gen_packet(input bit noisy);
    int  rem;
    int  cnt;
    int  n_pix;
    int  w;
    bit  rep;
    if (!gen_state.expect_header || gen_state.finished ||
        (noisy && $urandom_range(0, 99) < 10)) begin
      push_byte(8'($urandom_range(0, 255)));
      return;
    end
    w   = eff_dim(cfg.image_width);
    rem = (int'(gen_state.line_pos) < w) ? (w - int'(gen_state.line_pos)) : 1;
    rep = 1'($urandom_range(0, 1));
    if (rep || (noisy && $urandom_range(0, 99) < 15)) begin
      // Repeat counts may pass the line end; so may the odd broken literal.
      cnt = $urandom_range(0, 127);
    end else begin
      cnt = $urandom_range(0, ((rem < 128) ? rem : 128) - 1);
    end
    push_byte({rep, cnt[6:0]});
    n_pix = rep ? 1 : cnt + 1;
    repeat (n_pix * pixel_bytes(cfg)) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_BPP:    cfg.bytes_per_pixel = val[BPP_W-1:0];
      REG_WIDTH:  cfg.image_width     = val[DIM_FIELD_W-1:0];
      REG_HEIGHT: cfg.image_height    = val[DIM_FIELD_W-1:0];
      REG_RTL:    cfg.right_to_left   = val[0];
      REG_TTB:    cfg.top_to_bottom   = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input int bpp, input int w, input int h,
                            input int rtl, input int ttb);
    write_reg(REG_BPP, bpp);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RTL, rtl);
    write_reg(REG_TTB, ttb);
  endtask

  // Header bytes give no span, so a drain wait follows once the queues empty.
  task automatic wait_idle();
    while (byte_q.size() != 0 || bytes_in.valid === 1'b1) @(posedge clk);
    while (span_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int bpp, input int w, input int h, input int rtl,
                           input int ttb, input int n_items, input bit noisy);
    int stop_at;
    set_config(bpp, w, h, rtl, ttb);
    stop_at = item_count + n_items;
    while (item_count < stop_at) gen_packet(noisy);
    wait_idle();
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      failed = 1'b1;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Source side: an offered request stays up until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      bytes_in.valid <= 1'b0;
    end else if (bytes_in.valid && !byte_taken) begin
      bytes_in.valid <= 1'b1;
    end else if (byte_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 34)) begin
      bytes_in.valid     <= 1'b1;
      bytes_in.data_byte <= byte_q[0];
    end else begin
      bytes_in.valid <= 1'b0;
    end
  end

  // Sink side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holds_served != hold_reqs) begin
      holds_served = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      spans_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      spans_out.ready <= 1'b0;
      hold_left--;
    end else begin
      spans_out.ready <= !(gaps_on && $urandom_range(0, 99) < 34);
    end
  end

  // Spans are checked before the new byte's prediction is queued.
  always @(posedge clk) begin
    span_t exp_span;
    span_t new_span;
    byte_taken = !rst && bytes_in.valid === 1'b1 && bytes_in.ready === 1'b1;
    if (!rst && spans_out.valid === 1'b1 && spans_out.ready === 1'b1) begin
      if (span_q.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected span, expected none, actual pixel %h col %0d row %0d",
                 $time, spans_out.pixel_value, spans_out.start_column, spans_out.row);
      end else begin
        exp_span = span_q.pop_front();
        compare_field("pixel_value", exp_span.pixel_value, spans_out.pixel_value);
        compare_field("start_column", 32'(exp_span.start_column),
                      32'(spans_out.start_column));
        compare_field("row", 32'(exp_span.row), 32'(spans_out.row));
        compare_field("span_length", 32'(exp_span.span_length),
                      32'(spans_out.span_length));
        compare_field("image_done", 32'(exp_span.image_done), 32'(spans_out.image_done));
      end
    end
    if (byte_taken) begin
      if (decode_byte(chk_state, cfg, bytes_in.data_byte, new_span)) span_q.push_back(new_span);
      void'(byte_q.pop_front());
    end
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [7:0] opening[];
    opening = '{
      8'hFF, 8'h00,                          // longest repeat, cut at the line end
      8'h80, 8'hFF,                          // shortest repeat
      8'h00, 8'h5A,                          // single literal
      8'h02, 8'h01, 8'h02, 8'h04,
      8'h7F, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hC3, 8'h3C, 8'hAA, 8'h55,
      8'hF0, 8'h0F,                          // long literal dropped at the line end
      8'h81, 8'hE7
    };
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    bytes_in.valid = 1'b0;
    bytes_in.data_byte = '0;
    spans_out.ready = 1'b0;
    cfg = '{bytes_per_pixel: RST_BPP, image_width: RST_WIDTH, image_height: RST_HEIGHT,
            right_to_left: 1'b0, top_to_bottom: 1'b0};
    gen_state = '{expect_header: 1'b1, default: '0};
    chk_state = gen_state;
    item_count = 0;
    failed = 1'b0;
    gaps_on = 1'b1;
    byte_taken = 1'b0;
    hold_reqs = 0;
    holds_served = 0;
    hold_left = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_config(1, 16, 65535, 0, 0);
    foreach (opening[i]) push_byte(opening[i]);
    wait_idle();

    // Widest line leaves the line position far past the narrow width that follows.
    run_phase(4, 65535, 65535, 1, 1, 150, 1'b1);
    gaps_on = 1'b0;
    run_phase(7, 3, 50000, 0, 1, 300, 1'b0);
    gaps_on = 1'b1;
    hold_reqs++;
    run_phase(0, 0, 40000, 1, 0, 150, 1'b1);

    while (item_count < TARGET_ITEMS) begin
      int sel;
      int w;
      sel = $urandom_range(0, 9);
      if (sel == 0) w = 0;
      else if (sel == 1) w = 65535;
      else if (sel < 4) w = $urandom_range(1, 65535);
      else w = $urandom_range(1, 40);
      run_phase($urandom_range(0, 7), w, $urandom_range(30000, 65535),
                $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(60, 200), 1'b1);
    end

    // A zero height closes the image at the next line end; later bytes are dropped.
    set_config($urandom_range(1, 4), $urandom_range(1, 8), 0,
               $urandom_range(0, 1), $urandom_range(0, 1));
    while (!gen_state.finished) gen_packet(1'b0);
    repeat (10) push_byte(8'($urandom_range(0, 255)));
    wait_idle();
    repeat (20) @(posedge clk);

    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
